### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define TBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("tbc assertion failed");

// Property that must never hold.
`define TBC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("tbc forbidden condition");

`endif

### design/tbc_pkg.sv
`timescale 1ns / 1ps
package tbc_pkg;
	localparam int CoordW = 32;
	localparam int EpsW   = 16;
	localparam int DiffW  = CoordW + 1;
	localparam int SumW   = CoordW + 2;
	localparam int ProdW  = DiffW + SumW;
	localparam int CrossW = ProdW + 1;
	localparam int FracW  = 16;
	localparam int QuoW   = 34;            // quotient bits, top bit flags overflow
	localparam int RemW   = CrossW + QuoW; // divisor shifted left by QuoW-1
	localparam int NumCells = QuoW;
	localparam logic [EpsW-1:0] EpsReset = 16'd7;

	typedef struct packed {
		logic signed [CoordW-1:0] vert0_x;
		logic signed [CoordW-1:0] vert0_y;
		logic signed [CoordW-1:0] vert0_z;
		logic signed [CoordW-1:0] vert1_x;
		logic signed [CoordW-1:0] vert1_y;
		logic signed [CoordW-1:0] vert1_z;
		logic signed [CoordW-1:0] vert2_x;
		logic signed [CoordW-1:0] vert2_y;
		logic signed [CoordW-1:0] vert2_z;
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
	} tbc_req_t;

	typedef struct packed {
		logic signed [CoordW-1:0] weight_alpha;
		logic signed [CoordW-1:0] weight_beta;
		logic signed [CoordW-1:0] weight_gamma;
		logic                     degenerate;
	} tbc_rsp_t;

	// one divider slot travelling down the cell row
	typedef struct packed {
		logic              valid;
		logic              degen;
		logic              neg_a;
		logic              neg_b;
		logic [RemW-1:0]   rem_a;
		logic [RemW-1:0]   rem_b;
		logic [RemW-1:0]   dvs;
		logic [QuoW-1:0]   quo_a;
		logic [QuoW-1:0]   quo_b;
	} tbc_cell_t;
endpackage

### design/tbc_front.sv
`timescale 1ns / 1ps
module tbc_front import tbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tbc_req_t        req,
	input  logic [EpsW-1:0] eps,
	output tbc_cell_t       out
);
	logic signed [DiffW-1:0] a, b, c, d, e, f, g, h, i;
	logic signed [SumW-1:0]  ci, bh, ag, fi, eh, dg;
	logic [DiffW-1:0]        mag_a, mag_b;
	logic                    use_yz;

	always_comb begin
		a = {req.vert0_x[CoordW-1], req.vert0_x} - {req.vert2_x[CoordW-1], req.vert2_x};
		b = {req.vert1_x[CoordW-1], req.vert1_x} - {req.vert2_x[CoordW-1], req.vert2_x};
		c = {req.vert2_x[CoordW-1], req.vert2_x} - {req.point_x[CoordW-1], req.point_x};
		d = {req.vert0_y[CoordW-1], req.vert0_y} - {req.vert2_y[CoordW-1], req.vert2_y};
		e = {req.vert1_y[CoordW-1], req.vert1_y} - {req.vert2_y[CoordW-1], req.vert2_y};
		f = {req.vert2_y[CoordW-1], req.vert2_y} - {req.point_y[CoordW-1], req.point_y};
		g = {req.vert0_z[CoordW-1], req.vert0_z} - {req.vert2_z[CoordW-1], req.vert2_z};
		h = {req.vert1_z[CoordW-1], req.vert1_z} - {req.vert2_z[CoordW-1], req.vert2_z};
		i = {req.vert2_z[CoordW-1], req.vert2_z} - {req.point_z[CoordW-1], req.point_z};
		ci = {c[DiffW-1], c} + {i[DiffW-1], i};
		bh = {b[DiffW-1], b} + {h[DiffW-1], h};
		ag = {a[DiffW-1], a} + {g[DiffW-1], g};
		fi = {f[DiffW-1], f} + {i[DiffW-1], i};
		eh = {e[DiffW-1], e} + {h[DiffW-1], h};
		dg = {d[DiffW-1], d} + {g[DiffW-1], g};
		mag_a = a[DiffW-1] ? DiffW'(-a) : DiffW'(a);
		mag_b = b[DiffW-1] ? DiffW'(-b) : DiffW'(b);
		use_yz = (mag_a < {{(DiffW-EpsW){1'b0}}, eps}) &&
			(mag_b < {{(DiffW-EpsW){1'b0}}, eps});
	end

	// s1: operands of the three cross products (x*y - u*w)
	logic signed [DiffW-1:0] dx_s1 [3];
	logic signed [SumW-1:0]  dy_s1 [3];
	logic signed [DiffW-1:0] ux_s1 [3];
	logic signed [SumW-1:0]  uy_s1 [3];
	logic                    v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk) begin
		if (use_yz) begin
			dx_s1[0] <= d; dy_s1[0] <= bh; ux_s1[0] <= e; uy_s1[0] <= ag;
			dx_s1[1] <= e; dy_s1[1] <= ci; ux_s1[1] <= f; uy_s1[1] <= bh;
			dx_s1[2] <= d; dy_s1[2] <= ci; ux_s1[2] <= f; uy_s1[2] <= ag;
		end else begin
			dx_s1[0] <= a; dy_s1[0] <= eh; ux_s1[0] <= b; uy_s1[0] <= dg;
			dx_s1[1] <= b; dy_s1[1] <= fi; ux_s1[1] <= c; uy_s1[1] <= eh;
			dx_s1[2] <= a; dy_s1[2] <= fi; ux_s1[2] <= c; uy_s1[2] <= dg;
		end
	end

	// s2: six products
	logic signed [ProdW-1:0] pp_s2 [3];
	logic signed [ProdW-1:0] pm_s2 [3];
	// s3: det, alpha and beta numerators
	logic signed [CrossW-1:0] cr_s3 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pp_s2[k] <= dx_s1[k] * dy_s1[k];
			pm_s2[k] <= ux_s1[k] * uy_s1[k];
			cr_s3[k] <= {pp_s2[k][ProdW-1], pp_s2[k]} - {pm_s2[k][ProdW-1], pm_s2[k]};
		end
	end

	// s4: magnitudes, rounding bias, signs
	logic [CrossW-1:0] mdet, mna, mnb;
	tbc_cell_t         nxt;

	always_comb begin
		mdet = cr_s3[0][CrossW-1] ? CrossW'(-cr_s3[0]) : CrossW'(cr_s3[0]);
		mna  = cr_s3[1][CrossW-1] ? CrossW'(-cr_s3[1]) : CrossW'(cr_s3[1]);
		mnb  = cr_s3[2][CrossW-1] ? CrossW'(-cr_s3[2]) : CrossW'(cr_s3[2]);
		nxt.valid = v_s3;
		nxt.degen = (cr_s3[0] == '0);
		nxt.neg_a = cr_s3[1][CrossW-1] ^ cr_s3[0][CrossW-1];
		nxt.neg_b = ~(cr_s3[2][CrossW-1] ^ cr_s3[0][CrossW-1]);
		nxt.rem_a = RemW'({mna, {FracW{1'b0}}}) + RemW'(mdet >> 1);
		nxt.rem_b = RemW'({mnb, {FracW{1'b0}}}) + RemW'(mdet >> 1);
		nxt.dvs   = {mdet, {QuoW{1'b0}}} >> 1;
		nxt.quo_a = '0;
		nxt.quo_b = '0;
	end

	tbc_cell_t out_s4;
	always_ff @(posedge clk) out_s4 <= nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_comb begin
		out = out_s4;
		out.valid = v_s4;
	end
endmodule

### design/tbc_cell.sv
`timescale 1ns / 1ps
module tbc_cell import tbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tbc_cell_t din,
	output tbc_cell_t dout
);
	logic      ge_a, ge_b;
	tbc_cell_t nxt, data_q;
	logic      valid_q;

	// one restoring step on both lanes, divisor walks one bit right
	always_comb begin
		ge_a = din.rem_a >= din.dvs;
		ge_b = din.rem_b >= din.dvs;
		nxt = din;
		nxt.rem_a = ge_a ? din.rem_a - din.dvs : din.rem_a;
		nxt.rem_b = ge_b ? din.rem_b - din.dvs : din.rem_b;
		nxt.dvs   = din.dvs >> 1;
		nxt.quo_a = {din.quo_a[QuoW-2:0], ge_a};
		nxt.quo_b = {din.quo_b[QuoW-2:0], ge_b};
	end

	always_ff @(posedge clk) data_q <= nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else         valid_q <= din.valid;
	end

	always_comb begin
		dout = data_q;
		dout.valid = valid_q;
	end
endmodule

### design/triangle_barycentric_coords_top.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy stays low, results cannot be stalled.
// Pipeline: 4 front stages, a row of 34 divider cells (one quotient bit each), 1 out reg.
// Reset (arst_n low) clears all valid bits and loads eps_threshold with 7.
`include "assert_macros.svh"
module triangle_barycentric_coords_top import tbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tbc_req_t        req,
	output logic            done,
	output tbc_rsp_t        rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [EpsW-1:0] cfg_data
);
	localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};
	localparam logic signed [SumW-1:0]   OneQ   = SumW'(1) <<< FracW;

	// config: always ready; the user must write it only while idle, the block does not enforce this
	logic [EpsW-1:0] eps_q;
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        eps_q <= EpsReset;
		else if (cfg_valid) eps_q <= cfg_data;
	end

	// differences, cross products, divider setup
	tbc_cell_t chain [NumCells+1];

	tbc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_valid(start),
		.req    (req),
		.eps    (eps_q),
		.out    (chain[0])
	);

	// cell k yields quotient bit QuoW-1-k; the top bit marks overflow
	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		tbc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[k]),
			.dout  (chain[k+1])
		);
	end

	// sign, saturate, gamma
	function automatic logic signed [CoordW-1:0] sat_q(input logic [QuoW-1:0] q,
		input logic neg);
		logic [CoordW-1:0] lo;
		lo = q[CoordW-1:0];
		if (!neg) return (q > QuoW'(SatMax)) ? SatMax : $signed(lo);
		if (q > QuoW'({1'b0, SatMin})) return SatMin;
		return $signed(-lo);
	endfunction

	tbc_cell_t               tail;
	logic signed [CoordW-1:0] alpha, beta, gamma;
	logic signed [SumW-1:0]   gsum;
	tbc_rsp_t                 rsp_nxt;

	always_comb begin
		tail  = chain[NumCells];
		alpha = sat_q(tail.quo_a, tail.neg_a);
		beta  = sat_q(tail.quo_b, tail.neg_b);
		gsum  = OneQ - SumW'(alpha) - SumW'(beta);
		if (gsum > SumW'(SatMax))      gamma = SatMax;
		else if (gsum < SumW'(SatMin)) gamma = SatMin;
		else                           gamma = gsum[CoordW-1:0];
		rsp_nxt.degenerate = tail.degen;
		if (tail.degen) begin
			rsp_nxt.weight_alpha = '0;
			rsp_nxt.weight_beta  = '0;
			rsp_nxt.weight_gamma = '0;
		end else begin
			rsp_nxt.weight_alpha = alpha;
			rsp_nxt.weight_beta  = beta;
			rsp_nxt.weight_gamma = gamma;
		end
	end

	always_ff @(posedge clk) rsp <= rsp_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= tail.valid;
	end

	// a result only ever follows a request of fixed age
	`TBC_ASSERT(a_done_age, clk, arst_n, done |-> $past(start, 39))
	// a degenerate result carries zero alpha and gamma weights
	`TBC_ASSERT(a_degen_zero, clk, arst_n,
		(done && rsp.degenerate) |-> (rsp.weight_alpha == '0 && rsp.weight_gamma == '0))
	// threshold follows the last write
	`TBC_ASSERT(a_cfg_write, clk, arst_n,
		($past(cfg_valid) && $past(arst_n)) |-> (eps_q == $past(cfg_data)))
endmodule

### bench/triangle_barycentric_coords_top_tb.sv
`timescale 1ns / 1ps
// Bench for triangle_barycentric_coords_top.
// Requests go in at the falling edge. The monitor runs at the rising edge and
// works out the expected weights of every accepted request that has none typed in, using its own copy
// of eps_threshold. Each done pulse is checked against the oldest expected
// entry. The receiver cannot back-pressure, so only the sender idles.
module triangle_barycentric_coords_top_tb;
	import tbc_pkg::*;

	localparam int Latency = 39;
	localparam int NumRandom = 1550;
	localparam logic signed [31:0] One = 32'sd65536;

	typedef struct {
		tbc_req_t req;
		bit       typed;   // expected weights written in by hand
		tbc_rsp_t rsp;
	} dir_row_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	tbc_req_t        req;
	logic            done;
	tbc_rsp_t        rsp;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [EpsW-1:0] cfg_data;

	// side info travelling with the request being driven
	bit       drv_typed;
	tbc_rsp_t drv_rsp;

	logic [EpsW-1:0] eps_shadow;
	tbc_rsp_t        weights_q[$];
	int              n_fail;

	triangle_barycentric_coords_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Rounded Q16.16 quotient num/det, ties away from zero, clamped to 32 bits.
	function automatic longint q16_ratio(logic signed [127:0] num,
			logic signed [127:0] det, bit flip);
		bit           neg;
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] quo;
		neg = ((num < 0) != (det < 0)) != flip;
		n = (num < 0) ? -num : num;
		d = (det < 0) ? -det : det;
		n = n << FracW;
		quo = (n + (d >> 1)) / d;
		if (!neg)
			return (quo > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(quo);
		if (quo > 128'h8000_0000)
			return -64'sh8000_0000;
		return -longint'(quo);
	endfunction

	// Cramer's rule on the chosen pair of rows.
	function automatic tbc_rsp_t bary_weights(tbc_req_t q, logic [EpsW-1:0] eps);
		logic signed [127:0] a, b, c, d, e, f, g, h, i;
		logic signed [127:0] abs_a, abs_b, eps_w;
		logic signed [127:0] det, na, nb;
		longint              al, be, ga;
		tbc_rsp_t            r;
		a = $signed(q.vert0_x) - $signed(q.vert2_x);
		b = $signed(q.vert1_x) - $signed(q.vert2_x);
		c = $signed(q.vert2_x) - $signed(q.point_x);
		d = $signed(q.vert0_y) - $signed(q.vert2_y);
		e = $signed(q.vert1_y) - $signed(q.vert2_y);
		f = $signed(q.vert2_y) - $signed(q.point_y);
		g = $signed(q.vert0_z) - $signed(q.vert2_z);
		h = $signed(q.vert1_z) - $signed(q.vert2_z);
		i = $signed(q.vert2_z) - $signed(q.point_z);
		abs_a = (a < 0) ? -a : a;
		abs_b = (b < 0) ? -b : b;
		eps_w = $signed({112'd0, eps});
		if (abs_a < eps_w && abs_b < eps_w) begin
			// x rows near zero: y row with x+z row
			det = d * (b + h) - e * (a + g);
			na  = e * (c + i) - f * (b + h);
			nb  = d * (c + i) - f * (a + g);
		end else begin
			det = a * (e + h) - b * (d + g);
			na  = b * (f + i) - c * (e + h);
			nb  = a * (f + i) - c * (d + g);
		end
		r = '0;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		al = q16_ratio(na, det, 1'b0);
		be = q16_ratio(nb, det, 1'b1);
		ga = 64'sd65536 - al - be;
		if (ga > 64'sh7FFF_FFFF) ga = 64'sh7FFF_FFFF;
		if (ga < -64'sh8000_0000) ga = -64'sh8000_0000;
		r.weight_alpha = al[31:0];
		r.weight_beta  = be[31:0];
		r.weight_gamma = ga[31:0];
		return r;
	endfunction

	function automatic tbc_req_t mk_req(int v0x, int v0y, int v0z, int v1x, int v1y,
			int v1z, int v2x, int v2y, int v2z, int px, int py, int pz);
		tbc_req_t q;
		q = '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, px, py, pz};
		return q;
	endfunction

	function automatic int rnd_coord(int mode);
		case (mode)
			0: return int'($urandom);
			1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
				: 32'sh8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	// Random triangle: plain, small, extreme, thin in x (branch near eps),
	// or collinear (degenerate).
	function automatic tbc_req_t rnd_req();
		tbc_req_t q;
		int       mode;
		int       pick;
		pick = $urandom_range(0, 9);
		mode = (pick < 4) ? 0 : (pick < 8) ? 1 : 2;
		q = mk_req(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
		case ($urandom_range(0, 5))
			0, 1: begin
				// x differences straddle the threshold
				q.vert0_x = q.vert2_x + $signed($urandom_range(0, 140000)) - 70000;
				q.vert1_x = q.vert2_x + $signed($urandom_range(0, 140000)) - 70000;
				if ($urandom_range(0, 1) != 0) begin
					q.vert0_x = q.vert2_x + $signed($urandom_range(0, 20)) - 10;
					q.vert1_x = q.vert2_x + $signed($urandom_range(0, 20)) - 10;
				end
			end
			2: begin
				// vert1 on the line through vert0 and vert2
				q.vert1_x = q.vert2_x;
				q.vert1_y = q.vert2_y;
				q.vert1_z = q.vert2_z;
			end
			default: ;
		endcase
		return q;
	endfunction

	// Monitor: prediction on accept, checking on done.
	always @(posedge clk) begin
		tbc_rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				eps_shadow <= cfg_data;
			if (start && !busy)
				weights_q.push_back(drv_typed ? drv_rsp : bary_weights(req, eps_shadow));
			if (done) begin
				if (weights_q.size() == 0) begin
					$error("unexpected result");
					n_fail++;
				end else begin
					want = weights_q.pop_front();
					if (rsp.weight_alpha !== want.weight_alpha) begin
						$error("weight_alpha exp %0d got %0d", want.weight_alpha,
							rsp.weight_alpha);
						n_fail++;
					end
					if (rsp.weight_beta !== want.weight_beta) begin
						$error("weight_beta exp %0d got %0d", want.weight_beta,
							rsp.weight_beta);
						n_fail++;
					end
					if (rsp.weight_gamma !== want.weight_gamma) begin
						$error("weight_gamma exp %0d got %0d", want.weight_gamma,
							rsp.weight_gamma);
						n_fail++;
					end
					if (rsp.degenerate !== want.degenerate) begin
						$error("degenerate exp %0b got %0b", want.degenerate,
							rsp.degenerate);
						n_fail++;
					end
				end
			end
		end
	end

	// Drive one request and hold it until it is taken.
	task automatic send_req(tbc_req_t q, bit typed, tbc_rsp_t e);
		start = 1'b1;
		req = q;
		drv_typed = typed;
		drv_rsp = e;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
	endtask

	task automatic write_eps(logic [EpsW-1:0] val);
		start = 1'b0;
		cfg_valid = 1'b1;
		cfg_data = val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let the pipe empty so a register write sees the block idle.
	task automatic drain();
		start = 1'b0;
		while (weights_q.size() != 0)
			@(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	// Sender in bursts with random gaps; some bursts run back to back.
	task automatic send_random(int count);
		int burst;
		int gap;
		tbc_rsp_t none;
		none = '0;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			for (int k = 0; k < burst && count > 0; k++) begin
				send_req(rnd_req(), 1'b0, none);
				count--;
			end
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b0;
	endtask

	initial begin
		dir_row_t          dir_tbl[$];
		dir_row_t          row;
		tbc_rsp_t          zero_w;
		tbc_rsp_t          degen_w;
		tbc_rsp_t          unit_a;
		logic [EpsW-1:0]   eps_set[4];
		int                share;

		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		drv_typed = 1'b0;
		drv_rsp = '0;
		eps_shadow = EpsReset;
		n_fail = 0;
		arst_n = 1'b0;

		zero_w = '0;
		degen_w = '0;
		degen_w.degenerate = 1'b1;
		unit_a = '0;
		unit_a.weight_alpha = One;

		// all-equal vertices collapse to a zero determinant
		row = '{mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen_w};
		dir_tbl.push_back(row);
		row.req = {12{32'sh7FFF_FFFF}};
		dir_tbl.push_back(row);
		row.req = {12{32'sh8000_0000}};
		dir_tbl.push_back(row);
		// unit triangle, point on vert0 / vert1 / vert2
		row = '{mk_req(One, 0, 0, 0, One, 0, 0, 0, 0, One, 0, 0), 1'b1, unit_a};
		dir_tbl.push_back(row);
		row.rsp = zero_w;
		row.rsp.weight_beta = One;
		row.req.point_x = 0;
		row.req.point_y = One;
		dir_tbl.push_back(row);
		row.rsp = zero_w;
		row.rsp.weight_gamma = One;
		row.req.point_y = 0;
		dir_tbl.push_back(row);
		// the rest through the predictor
		row.typed = 1'b0;
		row.req = mk_req(One, 0, 0, 0, One, 0, 0, 0, 0, One / 3, One / 3, 0);
		dir_tbl.push_back(row);
		row.req = mk_req(One, 0, 0, 0, One, 0, 0, 0, 0, 1, 1, 0);  // rounding ties
		dir_tbl.push_back(row);
		// x differences tiny: y row with x+z row
		row.req = mk_req(3, One, 0, -2, 0, One, 0, 0, 0, 1, 100, 200);
		dir_tbl.push_back(row);
		row.req = mk_req(6, One, 0, 6, 0, One, 0, 0, 0, 1, 100, 200);
		dir_tbl.push_back(row);
		row.req = mk_req(7, One, 0, 7, 0, One, 0, 0, 0, 1, 100, 200);
		dir_tbl.push_back(row);
		// tiny determinant, huge numerator: saturation both ways
		row.req = mk_req(1, 0, 0, 0, 1, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
		dir_tbl.push_back(row);
		row.req = mk_req(1, 0, 0, 0, 1, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		dir_tbl.push_back(row);
		// widest differences
		row.req = mk_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		dir_tbl.push_back(row);
		row.req = mk_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		dir_tbl.push_back(row);
		// collinear in x and y only
		row.req = mk_req(One, One, 5, 2 * One, 2 * One, 9, 0, 0, 0, 7, 8, 9);
		dir_tbl.push_back(row);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table at the reset threshold, back to back
		foreach (dir_tbl[k])
			send_req(dir_tbl[k].req, dir_tbl[k].typed, dir_tbl[k].rsp);
		start = 1'b0;

		// threshold phases: reset value, off, widest, random
		eps_set[0] = EpsReset;
		eps_set[1] = '0;
		eps_set[2] = 16'hFFFF;
		eps_set[3] = EpsW'($urandom);
		share = NumRandom / 4;
		for (int p = 0; p < 4; p++) begin
			if (p != 0) begin
				drain();
				write_eps(eps_set[p]);
				// the thin-x rows behave differently per threshold
				foreach (dir_tbl[k])
					if (!dir_tbl[k].typed)
						send_req(dir_tbl[k].req, 1'b0, zero_w);
				start = 1'b0;
			end
			send_random(share);
		end

		drain();
		if (n_fail == 0)
			$display("triangle_barycentric_coords_top: match");
		else
			$display("triangle_barycentric_coords_top: mismatch");
		$finish;
	end

	// Hard stop: about 1600 requests with gaps, plus drains.
	initial begin
		#5ms;
		$display("triangle_barycentric_coords_top: mismatch");
		$finish;
	end
endmodule

### files.f
+incdir+design
design/tbc_pkg.sv
design/tbc_front.sv
design/tbc_cell.sv
design/triangle_barycentric_coords_top.sv
bench/triangle_barycentric_coords_top_tb.sv
